### design/wgm_pkg.sv
// Shared types, constants and helpers for the glob matcher.
package wgm_pkg;

  localparam int unsigned MaxPattern = 64;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] CfgCaseSensitive = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExactMode     = 1'b1;

  localparam logic [7:0] StarChar   = 8'h2A;
  localparam logic [7:0] QuesChar   = 8'h3F;
  localparam logic [7:0] UpperA     = 8'h41;
  localparam logic [7:0] UpperZ     = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdText   = 2'd2,
    CmdEnd    = 2'd3
  } cmd_e;

  typedef enum logic {
    CtlEmpty = 1'b0,
    CtlFull  = 1'b1
  } ctl_state_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Strobes from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic finish;
  } dp_cmd_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic case_sens);
    logic [7:0] r;
    r = b;
    if (!case_sens && (b inside {[UpperA:UpperZ]})) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

endpackage

### design/wgm_ctrl.sv
// Handshake controller: output register occupancy and command strobes.
module wgm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  wgm_pkg::cmd_e    in_cmd_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wgm_pkg::dp_cmd_t dp_cmd_o
);

  wgm_pkg::ctl_state_e state_q, state_d;
  logic accept;

  // Outputs
  always_comb begin
    out_valid_o = (state_q == wgm_pkg::CtlFull);
    // Hold only an end-of-text that would overwrite an untaken result.
    in_stall_o  = (state_q == wgm_pkg::CtlFull) && out_stall_i &&
                  (in_cmd_i == wgm_pkg::CmdEnd);
    accept      = in_valid_i && !in_stall_o;
    dp_cmd_o    = '0;
    if (accept) begin
      case (in_cmd_i)
        wgm_pkg::CmdClear:  dp_cmd_o.clear  = 1'b1;
        wgm_pkg::CmdAppend: dp_cmd_o.append = 1'b1;
        wgm_pkg::CmdText:   dp_cmd_o.text   = 1'b1;
        wgm_pkg::CmdEnd:    dp_cmd_o.finish = 1'b1;
        default:            dp_cmd_o        = '0;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wgm_pkg::CtlEmpty: begin
        if (dp_cmd_o.finish) state_d = wgm_pkg::CtlFull;
      end
      wgm_pkg::CtlFull: begin
        if (dp_cmd_o.finish) begin
          state_d = wgm_pkg::CtlFull;
        end else if (!out_stall_i) begin
          state_d = wgm_pkg::CtlEmpty;
        end
      end
      default: state_d = wgm_pkg::CtlEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wgm_pkg::CtlEmpty;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/wgm_datapath.sv
// Pattern store, active position set with star closure, and result register.
module wgm_datapath #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MaxPattern
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wgm_pkg::dp_cmd_t               dp_cmd_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           cfg_we_i,
  input  logic [wgm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wgm_pkg::CfgDataW-1:0]   cfg_data_i,
  output wgm_pkg::out_item_t             result_o
);

  localparam int unsigned NumPos = MAX_PATTERN + 1;
  localparam int unsigned LenW   = $clog2(NumPos);
  localparam int unsigned IdxW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned Levels = $clog2(NumPos);

  logic [7:0]        store_q [MAX_PATTERN];
  logic [LenW-1:0]   len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [NumPos-1:0] act_q, act_d;
  logic              case_sens_q, case_sens_d;
  logic              exact_q, exact_d;
  wgm_pkg::out_item_t result_q;

  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] lit_hit;
  logic [NumPos-1:0]      prop;
  logic [NumPos-1:0]      cur_set;
  logic [NumPos-1:0]      nxt_set;
  logic [7:0]             text_fold;
  logic                   room;

  // Prefix scan: a position turns active through any run of stars behind it.
  // prop[j] links position j-1 to j.
  function automatic logic [NumPos-1:0] close_set(input logic [NumPos-1:0] act,
                                                 input logic [NumPos-1:0] link);
    logic [NumPos-1:0] g;
    logic [NumPos-1:0] p;
    g = act;
    p = link;
    for (int lvl = 0; lvl < Levels; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    return g;
  endfunction

  assign text_fold = wgm_pkg::fold_byte(data_byte_i, case_sens_q);
  assign room      = (len_q < LenW'(MAX_PATTERN));

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_lane
    logic [7:0] pat_byte;
    logic       in_pat;
    assign pat_byte   = store_q[g];
    assign in_pat     = (LenW'(g) < len_q);
    assign star[g]    = in_pat && !exact_q && (pat_byte == wgm_pkg::StarChar);
    assign lit_hit[g] = in_pat && !star[g] &&
                        ((!exact_q && (pat_byte == wgm_pkg::QuesChar)) ||
                         (wgm_pkg::fold_byte(pat_byte, case_sens_q) == text_fold));
  end

  assign prop    = {star, 1'b0};
  assign cur_set = close_set(act_q, prop);
  // A star keeps its position; a matching byte moves one position on.
  assign nxt_set = {1'b0, cur_set[MAX_PATTERN-1:0] & star} |
                   {cur_set[MAX_PATTERN-1:0] & lit_hit, 1'b0};

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    act_d       = act_q;
    case_sens_d = case_sens_q;
    exact_d     = exact_q;
    if (dp_cmd_i.clear) begin
      len_d = '0;
      ovf_d = 1'b0;
      act_d = NumPos'(1);
    end else if (dp_cmd_i.append) begin
      if (room) begin
        len_d = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      act_d = NumPos'(1);
    end else if (dp_cmd_i.text) begin
      act_d = close_set(nxt_set, prop);
    end else if (dp_cmd_i.finish) begin
      act_d = NumPos'(1);
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        wgm_pkg::CfgCaseSensitive: case_sens_d = cfg_data_i[0];
        wgm_pkg::CfgExactMode:     exact_d     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      act_q       <= NumPos'(1);
      case_sens_q <= 1'b1;
      exact_q     <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      act_q       <= act_d;
      case_sens_q <= case_sens_d;
      exact_q     <= exact_d;
    end
  end

  // Store and result carry no reset.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.append && room) begin
      store_q[len_q[IdxW-1:0]] <= data_byte_i;
    end
    if (dp_cmd_i.finish) begin
      result_q.matched          <= cur_set[len_q] && !ovf_q;
      result_q.pattern_overflow <= ovf_q;
    end
  end

  assign result_o = result_q;

endmodule

### design/wildcard_glob_matcher.sv
// Glob matcher top level: '*' and '?' wildcards over a streamed text.
// Throughput: one transaction per cycle while in_stall_o is low.
// The end-of-text result is registered and shows in the cycle after acceptance.
// A text byte does closure, step and closure over all positions in the cycle that accepts it.
// Input stalls only when an end of text meets a result still not taken.
// Reset: empty pattern, position 0 active, case_sensitive 1, exact_mode 0; store and result undefined.
module wildcard_glob_matcher #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MaxPattern
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wgm_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wgm_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [wgm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wgm_pkg::CfgDataW-1:0]  cfg_data_i
);

  wgm_pkg::dp_cmd_t dp_cmd;

  wgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  wgm_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .data_byte_i (in_data_i.data_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (out_data_o)
  );

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.matched && out_data_o.pattern_overflow))
    else $error("match reported on an overflowed pattern");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.command == wgm_pkg::CmdEnd)) |=> out_valid_o)
    else $error("end of text produced no result");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (in_data_i.command == wgm_pkg::CmdEnd)))
    else $error("result appeared without an end of text");

endmodule

### tb/tb.sv
// Self-checking testbench for the streaming glob matcher with '*' and '?' wildcards.
`timescale 1ns / 1ps

module tb;
  import wgm_pkg::*;

  localparam int RandItems   = 1040;
  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int HoldPhase   = 12;

  typedef enum logic [1:0] {
    RowItem,
    RowCaseReg,
    RowExactReg
  } row_kind_e;

  typedef enum logic [1:0] {
    RxFree,
    RxLight,
    RxHeavy,
    RxToggle
  } rx_mode_e;

  typedef bit [MaxPattern:0] live_t;

  typedef struct {
    row_kind_e kind;
    in_item_t  item;
    int        reps;
    bit        pinned;
    out_item_t want;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Matcher state as the testbench tracks it.
  logic [7:0]        pat_mem [MaxPattern];
  int                pat_len     = 0;
  bit                pat_ovf     = 1'b0;
  live_t             live        = live_t'(1);
  bit                case_sens_m = 1'b1;
  bit                exact_m     = 1'b0;
  out_item_t         pending_verdicts[$];

  stim_row_t dir_rows[$];
  int        items_sent;
  int        verdicts_seen;
  int        hits_seen;
  int        ovf_seen;
  int        fail_count;
  int        quiet;
  int        burst_left;
  int        hold_left;
  int        rx_left;
  bit        hold_req;
  rx_mode_e  rx_mode = RxFree;
  bit [3:0]  cfg_seen = 4'b0100;

  wildcard_glob_matcher u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (!case_sens_m && b >= UpperA && b <= UpperZ) begin
      return b + CaseOffset;
    end
    return b;
  endfunction

  function automatic bit is_wild_star(input int i);
    return !exact_m && pat_mem[i] == StarChar;
  endfunction

  // Let every live star also cover the position after it.
  function automatic void close_live();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && is_wild_star(i)) live[i+1] = 1'b1;
    end
  endfunction

  // Advance the live-position set by one transaction; returns 1 when a verdict is due.
  function automatic bit track_match(input in_item_t it, output out_item_t verdict);
    live_t      nxt;
    logic [7:0] t;
    verdict = '0;
    case (it.command)
      CmdClear: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        live    = live_t'(1);
      end
      CmdAppend: begin
        if (pat_len < MaxPattern) begin
          pat_mem[pat_len] = it.data_byte;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        live = live_t'(1);
      end
      CmdText: begin
        nxt = '0;
        t   = fold_case(it.data_byte);
        close_live();
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (is_wild_star(i)) begin
              nxt[i] = 1'b1;
            end else if ((!exact_m && pat_mem[i] == QuesChar) ||
                         fold_case(pat_mem[i]) == t) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        live = nxt;
        close_live();
      end
      default: begin
        close_live();
        verdict.matched          = live[pat_len] && !pat_ovf;
        verdict.pattern_overflow = pat_ovf;
        live = live_t'(1);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void add_row(input row_kind_e k, input cmd_e c, input logic [7:0] d,
                                  input int reps, input bit pinned, input bit m, input bit o);
    stim_row_t row;
    row.kind                  = k;
    row.item.command          = c;
    row.item.data_byte        = d;
    row.reps                  = reps;
    row.pinned                = pinned;
    row.want.matched          = m;
    row.want.pattern_overflow = o;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] lc;
    lc = "a" + 8'($urandom_range(0, 2));
    return ($urandom_range(0, 1) != 0) ? lc - CaseOffset : lc;
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return StarChar;
    if (r < 35) return QuesChar;
    if (r < 88) return pick_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one transaction in bursts with random gaps; predict once it is accepted.
  task automatic push_item(input in_item_t it, input bit pinned, input out_item_t pinned_val);
    int        gap;
    out_item_t verdict;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (track_match(it, verdict)) pending_verdicts.push_back(pinned ? pinned_val : verdict);
    items_sent++;
  endtask

  // Drop valid and wait until every verdict is back and the pipeline is quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input bit v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgCaseSensitive) begin
      case_sens_m = v;
    end else begin
      exact_m = v;
    end
    cfg_seen[{case_sens_m, exact_m}] = 1'b1;
  endtask

  task automatic load_pattern();
    int       len;
    int       r;
    in_item_t it;
    if ($urandom_range(0, 9) != 0) begin
      it.command   = CmdClear;
      it.data_byte = 8'($urandom_range(0, 255));
      push_item(it, 1'b0, '0);
    end
    r = $urandom_range(0, 99);
    if (r < 84) begin
      len = $urandom_range(0, 8);
    end else if (r < 96) begin
      len = $urandom_range(9, 30);
    end else begin
      len = $urandom_range(MaxPattern - 2, MaxPattern + 4);
    end
    it.command = CmdAppend;
    repeat (len) begin
      it.data_byte = pick_pat_byte();
      push_item(it, 1'b0, '0);
    end
  endtask

  // Stream one text, mostly shaped to fit the loaded pattern, then end it when finish is set.
  task automatic send_text(input bit finish);
    logic [7:0] txt[$];
    logic [7:0] b;
    in_item_t   it;
    if ($urandom_range(0, 4) != 0) begin
      for (int k = 0; k < pat_len; k++) begin
        b = pat_mem[k];
        if (!exact_m && b == StarChar) begin
          repeat ($urandom_range(0, 3)) txt.push_back(pick_pat_byte());
        end else if (!exact_m && b == QuesChar) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end else if (((b >= "a" && b <= "z") || (b >= UpperA && b <= UpperZ)) &&
                     $urandom_range(0, 3) == 0) begin
          txt.push_back(b ^ CaseOffset);
        end else begin
          txt.push_back(b);
        end
      end
      if (txt.size() != 0 && $urandom_range(0, 5) == 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = pick_letter();
      end
    end else begin
      repeat ($urandom_range(0, 6)) txt.push_back(pick_pat_byte());
    end
    foreach (txt[k]) begin
      it.command   = CmdText;
      it.data_byte = txt[k];
      push_item(it, 1'b0, '0);
      // Occasional noise: any command with any byte, mid-text.
      if ($urandom_range(0, 49) == 0) begin
        it.command   = cmd_e'($urandom_range(0, 3));
        it.data_byte = 8'($urandom_range(0, 255));
        push_item(it, 1'b0, '0);
      end
    end
    if (finish) begin
      it.command   = CmdEnd;
      it.data_byte = 8'($urandom_range(0, 255));
      push_item(it, 1'b0, '0);
    end
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 120);
      end
      rx_left--;
      case (rx_mode)
        RxFree:  out_stall <= 1'b0;
        RxLight: out_stall <= ($urandom_range(0, 3) == 0);
        RxHeavy: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (out_data.matched) hits_seen++;
      if (out_data.pattern_overflow) ovf_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("result with no expectation pending: matched %0b pattern_overflow %0b",
               out_data.matched, out_data.pattern_overflow);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_data.matched);
          fail_count++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b",
                 want.pattern_overflow, out_data.pattern_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $error("no transaction for %0d cycles, %0d results outstanding",
               quiet, pending_verdicts.size());
        $display("** wildcard_glob_matcher: FAILED **");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  initial begin
    int target;
    int n_texts;
    int phase;

    add_row(RowItem, CmdEnd, 8'hFF, 1, 1'b1, 1'b1, 1'b0);     // empty pattern, empty text
    add_row(RowItem, CmdText, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b1, 1'b0, 1'b0);     // empty pattern, one byte
    add_row(RowItem, CmdAppend, StarChar, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, 8'hFF, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b1, 1'b1, 1'b0);     // lone star takes anything
    add_row(RowItem, CmdClear, 8'hFF, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdAppend, "A", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdAppend, QuesChar, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, "A", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, 8'h80, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    // Lower case text against upper case pattern: the live set empties.
    add_row(RowItem, CmdText, "a", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, "x", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowCaseReg, CmdClear, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, "a", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, "Z", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowExactReg, CmdClear, 8'h01, 1, 1'b0, 1'b0, 1'b0);
    // Append mid-text forgets the text so far; wildcards now literal.
    add_row(RowItem, CmdText, "A", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdAppend, StarChar, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, "a", 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, QuesChar, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdText, StarChar, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowExactReg, CmdClear, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowCaseReg, CmdClear, 8'h01, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdClear, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdAppend, "b", MaxPattern + 2, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b1, 1'b0, 1'b1);     // overflowed pattern
    add_row(RowItem, CmdClear, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(RowItem, CmdEnd, 8'h00, 1, 1'b1, 1'b1, 1'b0);     // clear drops the overflow

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        RowItem: begin
          repeat (dir_rows[r].reps) push_item(dir_rows[r].item, dir_rows[r].pinned,
                                              dir_rows[r].want);
        end
        RowCaseReg: begin
          settle();
          write_reg(CfgCaseSensitive, dir_rows[r].item.data_byte[0]);
        end
        default: begin
          settle();
          write_reg(CfgExactMode, dir_rows[r].item.data_byte[0]);
        end
      endcase
    end

    target = items_sent + RandItems;
    phase  = 0;
    while (items_sent < target) begin
      phase++;
      settle();
      // Walk all register combinations first, then change them at random.
      if (phase <= 4) begin
        write_reg(CfgCaseSensitive, 1'((phase - 1) >> 1));
        write_reg(CfgExactMode, 1'((phase - 1) & 1));
      end else begin
        if ($urandom_range(0, 2) == 0) write_reg(CfgCaseSensitive, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) write_reg(CfgExactMode, 1'($urandom_range(0, 1)));
      end
      n_texts = $urandom_range(1, 4);
      if (phase == HoldPhase) begin
        hold_req = 1'b1;
        n_texts  = 8;
      end
      if ($urandom_range(0, 9) < 7) load_pattern();
      repeat (n_texts) send_text(1'b1);
      // Sometimes leave a text open across the next register change.
      if ($urandom_range(0, 4) == 0) send_text(1'b0);
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d transactions over %0d phases; %0d verdicts (%0d matched, %0d overflow).",
             items_sent, phase, verdicts_seen, hits_seen, ovf_seen);
    $display("Register combinations visited %b, one output hold-off of %0d cycles.",
             cfg_seen, HoldCycles);
    if (fail_count == 0) begin
      $display("** wildcard_glob_matcher: PASSED **");
    end else begin
      $display("** wildcard_glob_matcher: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
design/wgm_pkg.sv
design/wgm_ctrl.sv
design/wgm_datapath.sv
design/wildcard_glob_matcher.sv
tb/tb.sv
